// File: hdl/bba_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bba_pkg : shared definitions for the brian's brain automaton
// cell state codes, mode and register codes, colors, the sequencer state
// type and the neighborhood window handed to the rule unit
// ---------------------------------------------------------------------------
package bba_pkg;

   // default grid store dimensions
   localparam int DEF_MAX_COLS = 256;
   localparam int DEF_MAX_ROWS = 256;

   // field widths
   localparam int DIM_W   = 9;
   localparam int CNT_W   = 17;
   localparam int COLOR_W = 32;

   // cell states
   typedef logic [1:0] cell_state_type;
   localparam cell_state_type ST_OFF   = 2'd0;
   localparam cell_state_type ST_FIRE  = 2'd1;
   localparam cell_state_type ST_DYING = 2'd2;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_GRID_COLS = 2'd0;
   localparam logic [1:0] REG_GRID_ROWS = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;

   // register reset values
   localparam logic [DIM_W-1:0] RST_GRID_COLS = 9'd256;
   localparam logic [DIM_W-1:0] RST_GRID_ROWS = 9'd256;
   localparam logic [CNT_W-1:0] RST_THRESHOLD = 17'd8;

   // pixel colors
   localparam logic [COLOR_W-1:0] COLOR_OFF   = 32'hFF000000;
   localparam logic [COLOR_W-1:0] COLOR_FIRE  = 32'hFFFFFFFF;
   localparam logic [COLOR_W-1:0] COLOR_DYING = 32'hFF2244AA;

   // an off cell fires with exactly this many firing neighbors
   localparam logic [3:0] BIRTH_NEIGHBOURS = 4'd2;

   // saturation point of the firing count
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // sequencer states
   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_READ,
      FSM_STEP_RUN,
      FSM_STEP_DRAIN,
      FSM_STEP_DONE
   } fsm_state_type;

   // 3x3 neighborhood of one cell: eight neighbor fire bits and the center
   typedef struct packed {
      logic [7:0]     nbr_fire;
      cell_state_type center;
      logic           in_grid;
   } window_type;

   // pixel color of a cell state
   function automatic logic [COLOR_W-1:0] color_of(input cell_state_type s);
      logic [COLOR_W-1:0] c;
      case (s)
         ST_FIRE:  c = COLOR_FIRE;
         ST_DYING: c = COLOR_DYING;
         default:  c = COLOR_OFF;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: hdl/brians_brain_automaton.sv
`default_nettype none
// ---------------------------------------------------------------------------
// brians_brain_automaton : three-state cellular automaton in on-chip store
// holds the grid in two banks and writes, reads or advances it on request
// ---------------------------------------------------------------------------
// Timing: a write or no-op request returns its result the cycle after the
// transfer; a read passes through the read state and then the response
// register. A generation step scans (MAX_ROWS+1)*(MAX_COLS+1) window
// positions at one per cycle through the single read port of the live
// bank, two line buffers and one shared rule unit, then passes through the
// drain and done states to the response register; the scan covers the
// whole store whatever the active grid size. Only one request is in
// flight; req_stall stays high until it finishes. After reset a clearing
// pass writes every cell of both banks to off, one per cycle, with req_stall high. Register writes are taken on any
// cycle and must only be issued while no request is in flight.
module brians_brain_automaton #(
   parameter int MAX_COLS = bba_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = bba_pkg::DEF_MAX_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [bba_pkg::CNT_W-1:0]     csr_wr_data,
   // requests
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [7:0]                    req_cell_col,
   input  wire logic [7:0]                    req_cell_row,
   input  wire logic [1:0]                    req_cell_value,
   // responses
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_read_state,
   output logic [bba_pkg::COLOR_W-1:0]        rsp_pixel_color,
   output logic [bba_pkg::CNT_W-1:0]          rsp_fire_count,
   output logic                               rsp_low_activity
);
   import bba_pkg::*;

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int XW     = $clog2(MAX_COLS + 1);
   localparam int YW     = $clog2(MAX_ROWS + 1);
   localparam int LBW    = $clog2(MAX_COLS);

   // configuration registers
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [CNT_W-1:0] thresh_ff, thresh_in;
   logic [DIM_W-1:0] eff_cols, eff_rows;

   // sequencer
   fsm_state_type state_ff, state_in;
   logic          accept;
   logic          clearing;
   logic          scanning;
   logic          step_done;
   logic          read_done;
   logic          scan_last;
   logic          clear_last;

   // request decode
   logic              cell_inside;
   logic [ADDR_W-1:0] cell_addr;
   logic              cell_we;
   cell_state_type    cell_wr_value;
   logic              rd_inside_ff, rd_inside_in;

   // grid banks
   cell_state_type bank_a_mem [DEPTH];
   cell_state_type bank_b_mem [DEPTH];
   cell_state_type bank_a_rd_ff;
   cell_state_type bank_b_rd_ff;
   logic           bank_a_we, bank_b_we;
   logic [ADDR_W-1:0] bank_wr_addr;
   logic [ADDR_W-1:0] bank_rd_addr;
   cell_state_type bank_wr_data;
   cell_state_type cur_rd;
   logic           current_bank_ff, current_bank_in;

   // scan counters
   logic [XW-1:0]     sx_ff, sx_in;
   logic [YW-1:0]     sy_ff, sy_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  last_count_ff, last_count_in;

   // window stage
   logic           b_valid_ff, b_valid_in;
   logic [XW-1:0]  bx_ff;
   logic [YW-1:0]  by_ff;
   cell_state_type lb_state_mem [MAX_COLS];
   logic           lb_fire_mem [MAX_COLS];
   cell_state_type lb_state_rd_ff;
   logic           lb_fire_rd_ff;
   logic           bx_in_mem;
   cell_state_type sample;
   cell_state_type lb_state_g;
   logic           lb_fire_g;
   logic           col_top, col_bot;
   cell_state_type col_mid;
   logic           w1_top_ff, w1_top_in, w1_bot_ff, w1_bot_in;
   cell_state_type w1_mid_ff, w1_mid_in;
   logic           w2_top_ff, w2_top_in, w2_mid_ff, w2_mid_in, w2_bot_ff, w2_bot_in;
   window_type     win;
   cell_state_type next_state;
   logic           out_valid;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   cell_state_type      rsp_state_ff, rsp_state_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_low_ff, rsp_low_in;
   cell_state_type      read_value;

   // effective grid size
   always_comb begin
      if (cols_ff == '0) begin
         eff_cols = DIM_W'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         eff_cols = DIM_W'(MAX_COLS);
      end else begin
         eff_cols = cols_ff;
      end
      if (rows_ff == '0) begin
         eff_rows = DIM_W'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         eff_rows = DIM_W'(MAX_ROWS);
      end else begin
         eff_rows = rows_ff;
      end
   end

   // configuration writes
   always_comb begin
      cols_in   = cols_ff;
      rows_in   = rows_ff;
      thresh_in = thresh_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_COLS: cols_in   = csr_wr_data[DIM_W-1:0];
            REG_GRID_ROWS: rows_in   = csr_wr_data[DIM_W-1:0];
            REG_THRESHOLD: thresh_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // request decode
   assign cell_inside   = ({1'b0, req_cell_col} < eff_cols) && ({1'b0, req_cell_row} < eff_rows);
   assign cell_addr     = ADDR_W'(ADDR_W'(req_cell_row) * ADDR_W'(MAX_COLS))
                        + ADDR_W'(req_cell_col);
   assign cell_wr_value = (req_cell_value == 2'd3) ? ST_OFF : req_cell_value;
   assign scan_last     = (sy_ff == YW'(MAX_ROWS)) && (sx_ff == XW'(MAX_COLS));
   assign clear_last    = (wr_addr_ff == ADDR_W'(DEPTH - 1));

   // sequencer outputs
   always_comb begin
      req_stall = (state_ff != FSM_IDLE) || (rsp_valid_ff && rsp_stall);
      accept    = req_valid && !req_stall;
      clearing  = (state_ff == FSM_CLEAR);
      scanning  = (state_ff == FSM_STEP_RUN);
      read_done = (state_ff == FSM_READ);
      step_done = (state_ff == FSM_STEP_DONE);
      cell_we   = accept && (req_mode == MODE_WRITE) && cell_inside;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: begin
            if (clear_last) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_READ: state_in = FSM_READ;
                  MODE_STEP: state_in = FSM_STEP_RUN;
                  default:   state_in = FSM_IDLE;
               endcase
            end
         end
         FSM_READ:       state_in = FSM_IDLE;
         FSM_STEP_RUN: begin
            if (scan_last) state_in = FSM_STEP_DRAIN;
         end
         FSM_STEP_DRAIN: state_in = FSM_STEP_DONE;
         FSM_STEP_DONE:  state_in = FSM_IDLE;
         default:        state_in = FSM_IDLE;
      endcase
   end

   // scan counters and generation bookkeeping
   always_comb begin
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      rd_addr_in      = rd_addr_ff;
      wr_addr_in      = wr_addr_ff;
      count_in        = count_ff;
      last_count_in   = last_count_ff;
      current_bank_in = current_bank_ff;
      b_valid_in      = scanning;
      rd_inside_in    = rd_inside_ff;
      if (clearing) begin
         wr_addr_in = wr_addr_ff + ADDR_W'(1);
      end
      if (accept) begin
         rd_inside_in = cell_inside;
      end
      if (accept && (req_mode == MODE_STEP)) begin
         sx_in      = '0;
         sy_in      = '0;
         rd_addr_in = '0;
         wr_addr_in = '0;
         count_in   = '0;
      end
      if (scanning) begin
         if (sx_ff == XW'(MAX_COLS)) begin
            sx_in = '0;
            sy_in = sy_ff + YW'(1);
         end else begin
            sx_in = sx_ff + XW'(1);
         end
         if ((sx_ff < XW'(MAX_COLS)) && (sy_ff < YW'(MAX_ROWS))) begin
            rd_addr_in = rd_addr_ff + ADDR_W'(1);
         end
      end
      if (out_valid) begin
         wr_addr_in = wr_addr_ff + ADDR_W'(1);
         if ((next_state == ST_FIRE) && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (step_done) begin
         last_count_in   = count_ff;
         current_bank_in = ~current_bank_ff;
      end
   end

   // bank port selection
   always_comb begin
      out_valid    = b_valid_ff && (by_ff != '0) && (bx_ff != '0);
      bank_rd_addr = (state_ff == FSM_IDLE) ? cell_addr : rd_addr_ff;
      if (clearing) begin
         bank_wr_addr = wr_addr_ff;
         bank_wr_data = ST_OFF;
      end else if (out_valid) begin
         bank_wr_addr = wr_addr_ff;
         bank_wr_data = next_state;
      end else begin
         bank_wr_addr = cell_addr;
         bank_wr_data = cell_wr_value;
      end
      bank_a_we = clearing || (cell_we && !current_bank_ff) || (out_valid && current_bank_ff);
      bank_b_we = clearing || (cell_we && current_bank_ff) || (out_valid && !current_bank_ff);
      cur_rd    = current_bank_ff ? bank_b_rd_ff : bank_a_rd_ff;
   end

   // grid bank a
   always_ff @(posedge clock) begin
      if (bank_a_we) begin
         bank_a_mem[bank_wr_addr] <= bank_wr_data;
      end
      bank_a_rd_ff <= bank_a_mem[bank_rd_addr];
   end

   // grid bank b
   always_ff @(posedge clock) begin
      if (bank_b_we) begin
         bank_b_mem[bank_wr_addr] <= bank_wr_data;
      end
      bank_b_rd_ff <= bank_b_mem[bank_rd_addr];
   end

   // new window column: row y from the bank, rows y-1 and y-2 from line buffers
   always_comb begin
      bx_in_mem  = (bx_ff < XW'(MAX_COLS));
      sample     = ((32'(by_ff) < 32'(eff_rows)) && (32'(bx_ff) < 32'(eff_cols)))
                 ? cur_rd : ST_OFF;
      lb_state_g = ((by_ff != '0) && bx_in_mem) ? lb_state_rd_ff : ST_OFF;
      lb_fire_g  = bx_in_mem && lb_fire_rd_ff;
      col_top    = lb_fire_g;
      col_mid    = lb_state_g;
      col_bot    = (sample == ST_FIRE);
   end

   // line buffers, read in the cycle before the window stage uses them
   always_ff @(posedge clock) begin
      if (b_valid_ff && bx_in_mem) begin
         lb_state_mem[bx_ff[LBW-1:0]] <= sample;
         lb_fire_mem[bx_ff[LBW-1:0]]  <= (lb_state_g == ST_FIRE);
      end
      lb_state_rd_ff <= lb_state_mem[sx_ff[LBW-1:0]];
      lb_fire_rd_ff  <= lb_fire_mem[sx_ff[LBW-1:0]];
   end

   // window shift, cleared at the left edge
   always_comb begin
      w1_top_in = w1_top_ff;
      w1_mid_in = w1_mid_ff;
      w1_bot_in = w1_bot_ff;
      w2_top_in = w2_top_ff;
      w2_mid_in = w2_mid_ff;
      w2_bot_in = w2_bot_ff;
      if (b_valid_ff) begin
         w1_top_in = col_top;
         w1_mid_in = col_mid;
         w1_bot_in = col_bot;
         if (bx_ff == '0) begin
            w2_top_in = 1'b0;
            w2_mid_in = 1'b0;
            w2_bot_in = 1'b0;
         end else begin
            w2_top_in = w1_top_ff;
            w2_mid_in = (w1_mid_ff == ST_FIRE);
            w2_bot_in = w1_bot_ff;
         end
      end
   end

   // neighborhood of cell (by-1, bx-1)
   always_comb begin
      win.nbr_fire = {w2_top_ff, w2_mid_ff, w2_bot_ff, w1_top_ff, w1_bot_ff,
                      col_top, (col_mid == ST_FIRE), col_bot};
      win.center   = w1_mid_ff;
      win.in_grid  = (by_ff != '0) && (bx_ff != '0)
                   && (32'(by_ff) <= 32'(eff_rows)) && (32'(bx_ff) <= 32'(eff_cols));
   end

   bba_rule u_rule (
      .win        (win),
      .next_state (next_state)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_state_in = rsp_state_ff;
      rsp_color_in = rsp_color_ff;
      rsp_count_in = rsp_count_ff;
      rsp_low_in   = rsp_low_ff;
      read_value   = rd_inside_ff ? cur_rd : ST_OFF;
      if (accept && (req_mode != MODE_READ) && (req_mode != MODE_STEP)) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = ST_OFF;
         rsp_color_in = '0;
         rsp_count_in = last_count_ff;
         rsp_low_in   = 1'b0;
      end else if (read_done) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = read_value;
         rsp_color_in = color_of(read_value);
         rsp_count_in = last_count_ff;
         rsp_low_in   = 1'b0;
      end else if (step_done) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = ST_OFF;
         rsp_color_in = '0;
         rsp_count_in = count_ff;
         rsp_low_in   = (count_ff < thresh_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FSM_CLEAR;
         cols_ff         <= RST_GRID_COLS;
         rows_ff         <= RST_GRID_ROWS;
         thresh_ff       <= RST_THRESHOLD;
         wr_addr_ff      <= '0;
         current_bank_ff <= 1'b0;
         last_count_ff   <= '0;
         b_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cols_ff         <= cols_in;
         rows_ff         <= rows_in;
         thresh_ff       <= thresh_in;
         wr_addr_ff      <= wr_addr_in;
         current_bank_ff <= current_bank_in;
         last_count_ff   <= last_count_in;
         b_valid_ff      <= b_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      rd_addr_ff   <= rd_addr_in;
      count_ff     <= count_in;
      rd_inside_ff <= rd_inside_in;
      bx_ff        <= sx_ff;
      by_ff        <= sy_ff;
      w1_top_ff    <= w1_top_in;
      w1_mid_ff    <= w1_mid_in;
      w1_bot_ff    <= w1_bot_in;
      w2_top_ff    <= w2_top_in;
      w2_mid_ff    <= w2_mid_in;
      w2_bot_ff    <= w2_bot_in;
      rsp_state_ff <= rsp_state_in;
      rsp_color_ff <= rsp_color_in;
      rsp_count_ff <= rsp_count_in;
      rsp_low_ff   <= rsp_low_in;
   end

   // response ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_state   = rsp_state_ff;
   assign rsp_pixel_color  = rsp_color_ff;
   assign rsp_fire_count   = rsp_count_ff;
   assign rsp_low_activity = rsp_low_ff;

endmodule
`default_nettype wire

// File: hdl/bba_rule.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bba_rule : next-state rule for one cell
// counts the firing neighbors of the window and applies the three-state
// rule; cells outside the active grid always go off
// ---------------------------------------------------------------------------
module bba_rule (
   input  bba_pkg::window_type     win,
   output bba_pkg::cell_state_type next_state
);
   import bba_pkg::*;

   logic [3:0] fire_sum;

   // firing neighbor count
   always_comb begin
      fire_sum = '0;
      for (int i = 0; i < 8; i++) begin
         fire_sum = fire_sum + 4'(win.nbr_fire[i]);
      end
   end

   // state transition
   always_comb begin
      if (!win.in_grid) begin
         next_state = ST_OFF;
      end else begin
         case (win.center)
            ST_FIRE:  next_state = ST_DYING;
            ST_DYING: next_state = ST_OFF;
            default:  next_state = (fire_sum == BIRTH_NEIGHBOURS) ? ST_FIRE : ST_OFF;
         endcase
      end
   end

endmodule
`default_nettype wire
